>>> sv/losl_pkg.sv
// Shared types and constants for the open-slot limiter.
// No dependencies; imported by losl_cell and lru_open_slot_limiter.
`timescale 1ns / 1ps

package losl_pkg;

  // default sizes
  localparam int NumResDefault = 64;
  localparam int StampWDefault = 48;

  // fixed field widths
  localparam int RegW     = 7;
  localparam int IdxInW   = 6;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;
  localparam int CfgIdxW  = 1;

  // register reset values
  localparam logic [RegW-1:0] MaxOpenReset  = RegW'(1);
  localparam logic [RegW-1:0] ResCountReset = RegW'(64);

  typedef enum logic {
    OP_ACCESS    = 1'b0,
    OP_CLOSE_ALL = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_OPEN  = 1'b0,
    CFG_RES_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  // commands broadcast to every cell
  typedef struct packed {
    logic stamp_wr;
    logic set_open;
    logic close_victim;
    logic clear_all;
  } cell_cmd_t;

  // control part of the scan token travelling along the row
  typedef struct packed {
    logic tok;
    logic found;
  } scan_ctl_t;

endpackage

>>> sv/losl_cell.sv
// One resource entry: open mark, use stamp and one stage of the lru scan.
// Depends on losl_pkg for the command and scan token types.
`timescale 1ns / 1ps

module losl_cell #(
  parameter int STAMP_WIDTH = losl_pkg::StampWDefault,
  parameter int IDX_W       = 6,
  parameter int CELL_IDX    = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  losl_pkg::cell_cmd_t   cmd_i,
  input  logic [IDX_W-1:0]      cmd_idx_i,
  input  logic [IDX_W-1:0]      victim_idx_i,
  input  logic [STAMP_WIDTH-1:0] new_stamp_i,
  input  losl_pkg::scan_ctl_t   scan_i,
  input  logic [STAMP_WIDTH-1:0] best_stamp_i,
  input  logic [IDX_W-1:0]      best_idx_i,
  output losl_pkg::scan_ctl_t   scan_o,
  output logic [STAMP_WIDTH-1:0] best_stamp_o,
  output logic [IDX_W-1:0]      best_idx_o,
  output logic                  open_o
);
  import losl_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic                   open_q, open_d;
  logic [STAMP_WIDTH-1:0] stamp_q;
  scan_ctl_t              scan_q;
  logic [STAMP_WIDTH-1:0] best_stamp_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic                   take;

  // this entry beats the best so far when open and strictly older
  assign take = scan_i.tok && open_q && (!scan_i.found || (stamp_q < best_stamp_i));

  // open mark update, close-all wins over everything else
  always_comb begin
    open_d = open_q;
    if (cmd_i.clear_all) begin
      open_d = 1'b0;
    end else begin
      if (cmd_i.close_victim && (victim_idx_i == MyIdx)) begin
        open_d = 1'b0;
      end
      if (cmd_i.set_open && (cmd_idx_i == MyIdx)) begin
        open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      scan_q <= '0;
    end else begin
      open_q       <= open_d;
      scan_q.tok   <= scan_i.tok;
      scan_q.found <= scan_i.found | take;
    end
  end

  // stamp store and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.stamp_wr && (cmd_idx_i == MyIdx)) begin
      stamp_q <= new_stamp_i;
    end
    best_stamp_q <= take ? stamp_q : best_stamp_i;
    best_idx_q   <= take ? MyIdx : best_idx_i;
  end

  assign scan_o       = scan_q;
  assign best_stamp_o = best_stamp_q;
  assign best_idx_o   = best_idx_q;
  assign open_o       = open_q;

endmodule

>>> sv/lru_open_slot_limiter.sv
// Evicts the least recently used open resource once max_open_limit (0 as 1) is reached.
// An access that hits, opens below the limit, is out of range or is a close-all
// is answered without a scan. An access that must evict sends a scan token
// down the row of NUM_RESOURCES cells, one cell per cycle, and no request is
// accepted until the scan ends. Two result registers sit on the master side,
// so the next request is let in while one result still waits there; the slave
// side stalls while both hold a result and while a scan runs.
// Depends on losl_pkg and losl_cell.
`timescale 1ns / 1ps

module lru_open_slot_limiter #(
  parameter int NUM_RESOURCES = losl_pkg::NumResDefault,
  parameter int STAMP_WIDTH   = losl_pkg::StampWDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [losl_pkg::InDataW-1:0]    s_axis_tdata,  // [5:0] resource_index
  input  logic                            s_axis_tuser,  // [0] opcode
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] status, [1] was_open, [2] evict_valid, [8:3] evicted_index,
  // [15:9] open_total, [16] stamp_saturated
  output logic [losl_pkg::OutDataW-1:0]   m_axis_tdata,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [losl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [losl_pkg::RegW-1:0]       cfg_data_i
);
  import losl_pkg::*;

  localparam int IdxW   = $clog2(NUM_RESOURCES);
  localparam int NResW  = $clog2(NUM_RESOURCES + 1);
  localparam int CmpW   = (NResW > RegW) ? NResW : RegW;
  localparam logic [STAMP_WIDTH-1:0] StampMax = '1;
  localparam logic [CmpW-1:0] NumRes = CmpW'(NUM_RESOURCES);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // configuration registers
  logic [RegW-1:0] max_open_q, res_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_open_q  <= MaxOpenReset;
      res_count_q <= ResCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_OPEN:  max_open_q  <= cfg_data_i;
        CFG_RES_COUNT: res_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  state_e                 state_q;
  logic                   start_q;
  logic [STAMP_WIDTH-1:0] gstamp_q;
  logic [RegW-1:0]        open_cnt_q;
  logic [IdxW-1:0]        pend_idx_q;
  logic                   out_valid_q, spare_valid_q;
  logic [OutDataW-1:0]    out_data_q, spare_data_q;

  // cell chain
  scan_ctl_t              chain_ctl   [NUM_RESOURCES+1];
  logic [STAMP_WIDTH-1:0] chain_stamp [NUM_RESOURCES+1];
  logic [IdxW-1:0]        chain_idx   [NUM_RESOURCES+1];
  logic [NUM_RESOURCES-1:0] open_vec;
  cell_cmd_t              cmd;
  logic [IdxW-1:0]        cmd_idx;

  // request decode
  logic                   acc, is_close, bad, do_access, hit, need_evict, scan_done;
  logic                   start_scan, res_push, out_pop;
  logic [OutDataW-1:0]    res_word;
  logic [RegW-1:0]        limit;
  logic [CmpW-1:0]        res_ext, cnt_eff, idx_ext;
  logic [IdxW-1:0]        cell_idx;
  logic [STAMP_WIDTH-1:0] gstamp_next;
  logic [IdxInW-1:0]      victim_out;

  assign s_axis_tready = (state_q == ST_IDLE) && !spare_valid_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_close      = (opcode_e'(s_axis_tuser) == OP_CLOSE_ALL);
  assign limit         = (max_open_q == '0) ? RegW'(1) : max_open_q;
  assign res_ext       = CmpW'(res_count_q);
  assign cnt_eff       = (res_ext > NumRes) ? NumRes : res_ext;
  assign idx_ext       = CmpW'(s_axis_tdata[IdxInW-1:0]);
  assign cell_idx      = IdxW'(s_axis_tdata[IdxInW-1:0]);
  assign bad           = !is_close && (idx_ext >= cnt_eff);
  assign do_access     = acc && !is_close && !bad;
  assign hit           = open_vec[cell_idx];
  assign need_evict    = !hit && (open_cnt_q >= limit);
  assign start_scan    = do_access && need_evict;
  assign gstamp_next   = (gstamp_q < StampMax) ? gstamp_q + 1'b1 : gstamp_q;
  assign scan_done     = (state_q == ST_SCAN) && chain_ctl[NUM_RESOURCES].tok;
  assign victim_out    = IdxInW'(chain_idx[NUM_RESOURCES]);
  assign out_pop       = out_valid_q && m_axis_tready;

  // broadcast commands to the cells
  always_comb begin
    cmd.stamp_wr     = do_access;
    cmd.set_open     = (do_access && !hit && !need_evict) || scan_done;
    cmd.close_victim = scan_done && chain_ctl[NUM_RESOURCES].found;
    cmd.clear_all    = acc && is_close;
    cmd_idx          = (state_q == ST_SCAN) ? pend_idx_q : cell_idx;
  end

  // scan token entry point
  assign chain_ctl[0]   = '{tok: start_q, found: 1'b0};
  assign chain_stamp[0] = '0;
  assign chain_idx[0]   = '0;

  // row of cells
  for (genvar g = 0; g < NUM_RESOURCES; g++) begin : g_cell
    losl_cell #(
      .STAMP_WIDTH (STAMP_WIDTH),
      .IDX_W       (IdxW),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .cmd_idx_i    (cmd_idx),
      .victim_idx_i (chain_idx[NUM_RESOURCES]),
      .new_stamp_i  (gstamp_next),
      .scan_i       (chain_ctl[g]),
      .best_stamp_i (chain_stamp[g]),
      .best_idx_i   (chain_idx[g]),
      .scan_o       (chain_ctl[g+1]),
      .best_stamp_o (chain_stamp[g+1]),
      .best_idx_o   (chain_idx[g+1]),
      .open_o       (open_vec[g])
    );
  end

  // result word produced in this cycle
  always_comb begin
    res_push = 1'b0;
    res_word = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (is_close) begin
            res_push = 1'b1;
            res_word = {7'b0, (gstamp_q == StampMax), RegW'(0), IdxInW'(0),
                        1'b0, 1'b0, STATUS_OK};
          end else if (bad) begin
            res_push = 1'b1;
            res_word = {7'b0, (gstamp_q == StampMax), open_cnt_q, IdxInW'(0),
                        1'b0, 1'b0, STATUS_BAD_INDEX};
          end else if (hit) begin
            res_push = 1'b1;
            res_word = {7'b0, (gstamp_next == StampMax), open_cnt_q, IdxInW'(0),
                        1'b0, 1'b1, STATUS_OK};
          end else if (!need_evict) begin
            res_push = 1'b1;
            res_word = {7'b0, (gstamp_next == StampMax), open_cnt_q + 1'b1,
                        IdxInW'(0), 1'b0, 1'b0, STATUS_OK};
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_push = 1'b1;
          if (chain_ctl[NUM_RESOURCES].found) begin
            res_word = {7'b0, (gstamp_q == StampMax), open_cnt_q, victim_out,
                        1'b1, 1'b0, STATUS_OK};
          end else begin
            res_word = {7'b0, (gstamp_q == StampMax), open_cnt_q + 1'b1,
                        IdxInW'(0), 1'b0, 1'b0, STATUS_OK};
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      start_q    <= 1'b0;
      gstamp_q   <= '0;
      open_cnt_q <= '0;
      pend_idx_q <= '0;
    end else begin
      start_q <= start_scan;
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (is_close) begin
              open_cnt_q <= '0;
            end else if (!bad) begin
              gstamp_q <= gstamp_next;
              if (start_scan) begin
                pend_idx_q <= cell_idx;
                state_q    <= ST_SCAN;
              end else if (!hit) begin
                open_cnt_q <= open_cnt_q + 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_IDLE;
            if (!chain_ctl[NUM_RESOURCES].found) begin
              open_cnt_q <= open_cnt_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // two result registers, the spare one fills while the head one waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      spare_valid_q <= 1'b0;
      spare_data_q  <= '0;
    end else if (!out_valid_q || out_pop) begin
      if (spare_valid_q) begin
        out_valid_q   <= 1'b1;
        out_data_q    <= spare_data_q;
        spare_valid_q <= res_push;
        spare_data_q  <= res_word;
      end else begin
        out_valid_q <= res_push;
        out_data_q  <= res_word;
      end
    end else if (res_push) begin
      spare_valid_q <= 1'b1;
      spare_data_q  <= res_word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> bench/tb_lru_open_slot_limiter.sv
// Self-checking bench for lru_open_slot_limiter: directed table, then random phases.
// Uses losl_pkg and the limiter RTL; checks against the table or an in-bench LRU predictor.
`timescale 1ns / 1ps

module tb_lru_open_slot_limiter;
  import losl_pkg::*;

  localparam int NumRes        = NumResDefault;
  localparam int StampW        = StampWDefault;
  localparam int WatchdogLimit = 2000;
  localparam int NumDirected   = 29;
  localparam int NumPhases     = 10;

  // one result, laid out as m_axis_tdata[16:0]
  typedef struct packed {
    logic              stamp_sat;
    logic [RegW-1:0]   open_total;
    logic [IdxInW-1:0] evicted;
    logic              evict_valid;
    logic              was_open;
    logic              status;
  } lru_result_t;

  // one row of the directed table: a register write or a request
  typedef struct packed {
    logic              is_cfg;
    cfg_idx_e          sel;
    logic [RegW-1:0]   val;
    opcode_e           op;
    logic [IdxInW-1:0] idx;
    logic              chk;
    lru_result_t       want;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [5:0] resource_index
  logic                s_axis_tuser  = 1'b0;  // [0] opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] status, [1] was_open, [2] evict_valid, [8:3] evicted_index,
  // [15:9] open_total, [16] stamp_saturated
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [RegW-1:0]     cfg_data_i    = '0;

  lru_open_slot_limiter #(
    .NUM_RESOURCES(NumRes),
    .STAMP_WIDTH  (StampW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // shadow state of the limiter
  logic              open_mark [NumRes];
  logic [StampW-1:0] use_stamp [NumRes];
  logic [StampW-1:0] global_stamp;
  int                open_count;
  logic [RegW-1:0]   lim_reg;
  logic [RegW-1:0]   cnt_reg;

  lru_result_t pending_results [$];
  int          mismatch_cnt = 0;
  int          quiet_cycles = 0;
  int          stall_left   = 0;
  bit          calm         = 1'b0;
  dir_row_t    dir_rows [NumDirected];

  int phase_lim   [NumPhases] = '{1, 4, 64, 8, 0, 127, 2, 16, 5, 3};
  int phase_cnt   [NumPhases] = '{64, 64, 64, 16, 127, 10, 1, 48, 64, 33};
  int phase_items [NumPhases] = '{100, 150, 100, 150, 80, 80, 20, 150, 120, 150};

  // apply one request to the shadow state and return the result it gives
  function automatic lru_result_t lru_apply(opcode_e op, logic [IdxInW-1:0] idx);
    lru_result_t       r;
    int                lim, cnt, victim, i;
    logic [StampW-1:0] best;
    logic              found;
    r   = '0;
    lim = (lim_reg == '0) ? 1 : int'(lim_reg);
    cnt = (int'(cnt_reg) > NumRes) ? NumRes : int'(cnt_reg);
    if (op == OP_CLOSE_ALL) begin
      for (i = 0; i < NumRes; i++) open_mark[i] = 1'b0;
      open_count = 0;
    end else if (int'(idx) >= cnt) begin
      r.status = STATUS_BAD_INDEX;
    end else begin
      // saturating stamp
      if (global_stamp != '1) global_stamp = global_stamp + 1'b1;
      use_stamp[idx] = global_stamp;
      if (open_mark[idx]) begin
        r.was_open = 1'b1;
      end else begin
        if (open_count >= lim) begin
          // oldest open entry, lowest index on a tie
          found  = 1'b0;
          victim = 0;
          best   = '0;
          for (i = 0; i < NumRes; i++) begin
            if (open_mark[i] && (!found || use_stamp[i] < best)) begin
              best   = use_stamp[i];
              victim = i;
              found  = 1'b1;
            end
          end
          if (found) begin
            open_mark[victim] = 1'b0;
            if (open_count > 0) open_count--;
            r.evict_valid = 1'b1;
            r.evicted     = IdxInW'(victim);
          end
        end
        open_mark[idx] = 1'b1;
        open_count++;
      end
    end
    r.open_total = RegW'(open_count);
    r.stamp_sat  = (global_stamp == '1);
    return r;
  endfunction

  function automatic lru_result_t mk_res(logic status, logic was_open, logic evict_valid,
                                         int evicted, int open_total);
    lru_result_t r;
    r             = '0;
    r.status      = status;
    r.was_open    = was_open;
    r.evict_valid = evict_valid;
    r.evicted     = IdxInW'(evicted);
    r.open_total  = RegW'(open_total);
    return r;
  endfunction

  function automatic dir_row_t chk_row(opcode_e op, int idx, lru_result_t want);
    dir_row_t d;
    d      = '0;
    d.sel  = CFG_MAX_OPEN;
    d.op   = op;
    d.idx  = IdxInW'(idx);
    d.chk  = 1'b1;
    d.want = want;
    return d;
  endfunction

  function automatic dir_row_t req_row(opcode_e op, int idx);
    dir_row_t d;
    d     = chk_row(op, idx, '0);
    d.chk = 1'b0;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e sel, int val);
    dir_row_t d;
    d        = '0;
    d.is_cfg = 1'b1;
    d.sel    = sel;
    d.val    = RegW'(val);
    d.op     = OP_ACCESS;
    return d;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t ns: mismatch on %s, expected %0d, got %0d", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // present one request, wait for it to be taken, record its expected result
  task automatic send_request(opcode_e op, logic [IdxInW-1:0] idx, logic chk,
                              lru_result_t want);
    lru_result_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(idx);
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = lru_apply(op, idx);
    pending_results.push_back(chk ? want : predicted);
    @(negedge clk_i);
  endtask

  // register write once the limiter has drained
  task automatic write_reg(cfg_idx_e sel, logic [RegW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_MAX_OPEN) lim_reg = val;
    else cnt_reg = val;
  endtask

  // result side back-pressure in short bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    lru_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lru_result_t'(m_axis_tdata[16:0]);
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
        if (got.was_open !== want.was_open)
          flag_mismatch("was_open", want.was_open, got.was_open);
        if (got.evict_valid !== want.evict_valid)
          flag_mismatch("evict_valid", want.evict_valid, got.evict_valid);
        if (got.evicted !== want.evicted)
          flag_mismatch("evicted_index", want.evicted, got.evicted);
        if (got.open_total !== want.open_total)
          flag_mismatch("open_total", want.open_total, got.open_total);
        if (got.stamp_sat !== want.stamp_sat)
          flag_mismatch("stamp_saturated", want.stamp_sat, got.stamp_sat);
      end
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                i, p, n, r, eff_cnt, eff_lim, span;
    opcode_e           op;
    logic [IdxInW-1:0] idx;

    // shadow state after reset
    for (i = 0; i < NumRes; i++) begin
      open_mark[i] = 1'b0;
      use_stamp[i] = '0;
    end
    global_stamp = '0;
    open_count   = 0;
    lim_reg      = MaxOpenReset;
    cnt_reg      = ResCountReset;

    // directed table: reset values, out of range, limit zero, lowered limit, stale opens
    dir_rows = '{
      chk_row(OP_ACCESS, 0, mk_res(STATUS_OK, 1'b0, 1'b0, 0, 1)),
      chk_row(OP_ACCESS, 0, mk_res(STATUS_OK, 1'b1, 1'b0, 0, 1)),
      chk_row(OP_ACCESS, 63, mk_res(STATUS_OK, 1'b0, 1'b1, 0, 1)),
      chk_row(OP_CLOSE_ALL, 63, mk_res(STATUS_OK, 1'b0, 1'b0, 0, 0)),
      chk_row(OP_ACCESS, 42, mk_res(STATUS_OK, 1'b0, 1'b0, 0, 1)),
      cfg_row(CFG_RES_COUNT, 40),
      chk_row(OP_ACCESS, 42, mk_res(STATUS_BAD_INDEX, 1'b0, 1'b0, 0, 1)),
      chk_row(OP_ACCESS, 63, mk_res(STATUS_BAD_INDEX, 1'b0, 1'b0, 0, 1)),
      // entry left open above the lowered count is still the victim
      chk_row(OP_ACCESS, 39, mk_res(STATUS_OK, 1'b0, 1'b1, 42, 1)),
      cfg_row(CFG_MAX_OPEN, 0),
      chk_row(OP_ACCESS, 5, mk_res(STATUS_OK, 1'b0, 1'b1, 39, 1)),
      cfg_row(CFG_MAX_OPEN, 3),
      req_row(OP_ACCESS, 1),
      req_row(OP_ACCESS, 2),
      req_row(OP_ACCESS, 1),
      req_row(OP_ACCESS, 3),
      req_row(OP_ACCESS, 4),
      // limit dropped below the open count
      cfg_row(CFG_MAX_OPEN, 1),
      req_row(OP_ACCESS, 6),
      req_row(OP_ACCESS, 7),
      cfg_row(CFG_RES_COUNT, 0),
      req_row(OP_ACCESS, 0),
      cfg_row(CFG_RES_COUNT, 127),
      cfg_row(CFG_MAX_OPEN, 127),
      req_row(OP_ACCESS, 63),
      req_row(OP_ACCESS, 21),
      req_row(OP_ACCESS, 42),
      req_row(OP_CLOSE_ALL, 0),
      req_row(OP_ACCESS, 0)
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_reg(dir_rows[k].sel, dir_rows[k].val);
      else send_request(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].chk, dir_rows[k].want);
    end

    // random phases, each under its own pair of register values
    for (p = 0; p < NumPhases; p++) begin
      write_reg(CFG_MAX_OPEN, RegW'(phase_lim[p]));
      write_reg(CFG_RES_COUNT, RegW'(phase_cnt[p]));
      calm    = (p == NumPhases - 1);
      eff_lim = (phase_lim[p] == 0) ? 1 : phase_lim[p];
      eff_cnt = (phase_cnt[p] > NumRes) ? NumRes : phase_cnt[p];
      // working set a little over twice the limit keeps evictions frequent
      span    = (2 * eff_lim + 2 < eff_cnt) ? 2 * eff_lim + 2 : eff_cnt;
      for (n = 0; n < phase_items[p]; n++) begin
        r  = $urandom_range(0, 99);
        op = (r < 3) ? OP_CLOSE_ALL : OP_ACCESS;
        if (r < 13 || span == 0) idx = IdxInW'($urandom_range(0, NumRes - 1));
        else idx = IdxInW'($urandom_range(0, span - 1));
        send_request(op, idx, 1'b0, '0);
      end
    end

    // drain and let the block settle
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> lru_open_slot_limiter.f
sv/losl_pkg.sv
sv/losl_cell.sv
sv/lru_open_slot_limiter.sv
bench/tb_lru_open_slot_limiter.sv
